### rtl/core/wavhp_pkg.sv
// shared types, constants and the lookup function of the wave header parser
package wavhp_pkg;

    localparam int OFFSET_WIDTH = 32;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [15:0] FMT_PCM  = 16'h0001;
    localparam logic [15:0] FMT_EXT  = 16'hFFFE;

    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [31:0] EXT_MIN_LEN = 32'd40;

    localparam logic [5:0] RIFF_LAST_IDX = 6'd11;
    localparam logic [5:0] HDR_LAST_IDX  = 6'd7;
    localparam logic [5:0] GUID_FIRST    = 6'd24;
    localparam logic [5:0] GUID_LAST     = 6'd39;
    localparam logic [5:0] IDX_MAX       = 6'd63;

    typedef enum logic [1:0] {
        PH_RIFF,
        PH_HDR,
        PH_FMT,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_EOF_RIFF,
        ST_NOT_WAVE,
        ST_EOF_CHUNK,
        ST_BAD_FORMAT,
        ST_EOF_EXT,
        ST_BAD_EXT,
        ST_SHORT_FILE
    } status_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_byte;
        logic       last_byte;
    } file_beat_t;

    typedef struct packed {
        status_t     status;
        logic        no_format;
        logic [31:0] sample_freq;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic        is_extensible;
        logic [31:0] data_offset;
    } hdr_info_t;

    // pcm subformat guid, byte by byte
    function automatic logic [7:0] pcm_guid_byte(input logic [3:0] pos);
        logic [7:0] val;
        unique case (pos)
            4'd0:    val = 8'h01;
            4'd6:    val = 8'h10;
            4'd8:    val = 8'h80;
            4'd11:   val = 8'haa;
            4'd13:   val = 8'h38;
            4'd14:   val = 8'h9b;
            4'd15:   val = 8'h71;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

### rtl/core/wavhp_parse.sv
// parse state registers and per-byte next-state and result logic
module wavhp_parse
    import wavhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  file_beat_t beat,
    output logic       res_fire,
    output hdr_info_t  res
);

    phase_t                  phase_reg, phase_next;
    logic [5:0]              idx_reg, idx_next;
    logic [31:0]             tag_reg, tag_next;
    logic [31:0]             len_reg, len_next;
    logic [31:0]             skip_reg, skip_next;
    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic [31:0]             rate_reg, rate_next;
    logic [15:0]             chan_reg, chan_next;
    logic [15:0]             bits_reg, bits_next;
    logic [15:0]             ftag_reg, ftag_next;
    logic                    fseen_reg, fseen_next;
    logic                    guid_ok_reg, guid_ok_next;
    logic                    done_reg, done_next;

    logic    emit;
    logic    ok;
    logic    nofmt;
    status_t status;
    logic    restart;
    logic    last;
    logic    lead;
    logic [7:0] b;
    logic [5:0] idx;

    assign restart = beat.first_byte;
    assign last    = beat.last_byte;
    assign b       = beat.file_byte;

    always_comb
    begin
        if (restart)
        begin
            phase_next   = PH_RIFF;
            idx_next     = '0;
            tag_next     = '0;
            len_next     = '0;
            skip_next    = '0;
            offset_next  = '0;
            rate_next    = '0;
            chan_next    = '0;
            bits_next    = '0;
            ftag_next    = '0;
            fseen_next   = 1'b0;
            guid_ok_next = 1'b1;
            done_next    = 1'b0;
        end
        else
        begin
            phase_next   = phase_reg;
            idx_next     = idx_reg;
            tag_next     = tag_reg;
            len_next     = len_reg;
            skip_next    = skip_reg;
            offset_next  = offset_reg;
            rate_next    = rate_reg;
            chan_next    = chan_reg;
            bits_next    = bits_reg;
            ftag_next    = ftag_reg;
            fseen_next   = fseen_reg;
            guid_ok_next = guid_ok_reg;
            done_next    = done_reg;
        end

        idx    = idx_next;
        emit   = 1'b0;
        ok     = 1'b0;
        nofmt  = 1'b0;
        status = ST_OK;
        lead   = 1'b0;

        if (!done_next)
        begin
            if (!(&offset_next))
            begin
                offset_next = offset_next + OFFSET_WIDTH'(1);
            end

            unique case (phase_next)
                PH_RIFF:
                begin
                    if (idx < 6'd4)
                    begin
                        tag_next[8*idx[1:0] +: 8] = b;
                    end
                    else if (idx >= 6'd8)
                    begin
                        len_next[8*idx[1:0] +: 8] = b;
                    end
                    if (idx < RIFF_LAST_IDX)
                    begin
                        idx_next = idx + 6'd1;
                        emit     = last;
                        status   = ST_EOF_RIFF;
                    end
                    else if (tag_next != TAG_RIFF || len_next != TAG_WAVE)
                    begin
                        emit   = 1'b1;
                        status = ST_NOT_WAVE;
                    end
                    else
                    begin
                        phase_next = PH_HDR;
                        idx_next   = '0;
                        tag_next   = '0;
                        len_next   = '0;
                        emit       = last;
                        status     = ST_EOF_CHUNK;
                    end
                end

                PH_HDR:
                begin
                    if (idx < 6'd4)
                    begin
                        tag_next[8*idx[1:0] +: 8] = b;
                    end
                    else
                    begin
                        len_next[8*idx[1:0] +: 8] = b;
                    end
                    if (idx < HDR_LAST_IDX)
                    begin
                        idx_next = idx + 6'd1;
                        emit     = last;
                        status   = ST_EOF_CHUNK;
                    end
                    else
                    begin
                        idx_next = '0;
                        if (tag_next == TAG_DATA)
                        begin
                            emit   = 1'b1;
                            status = ST_OK;
                            ok     = fseen_next;
                            nofmt  = !fseen_next;
                        end
                        else if (tag_next == TAG_FMT)
                        begin
                            phase_next   = PH_FMT;
                            skip_next    = (len_next < FMT_MIN_LEN) ? FMT_MIN_LEN : len_next;
                            guid_ok_next = 1'b1;
                            emit         = last;
                            status       = ST_SHORT_FILE;
                        end
                        else if (len_next == '0)
                        begin
                            skip_next = '0;
                            tag_next  = '0;
                            emit      = last;
                            status    = ST_EOF_CHUNK;
                        end
                        else
                        begin
                            skip_next  = len_next;
                            phase_next = PH_SKIP;
                            emit       = last;
                            status     = ST_SHORT_FILE;
                        end
                    end
                end

                PH_FMT:
                begin
                    if (idx < 6'd2)
                    begin
                        ftag_next[8*idx[0] +: 8] = b;
                    end
                    else if (idx < 6'd4)
                    begin
                        chan_next[8*idx[0] +: 8] = b;
                    end
                    else if (idx < 6'd8)
                    begin
                        rate_next[8*idx[1:0] +: 8] = b;
                    end
                    else if (idx == 6'd14 || idx == 6'd15)
                    begin
                        bits_next[8*idx[0] +: 8] = b;
                    end
                    else if (idx >= GUID_FIRST && idx <= GUID_LAST)
                    begin
                        if (b != pcm_guid_byte(4'(idx - GUID_FIRST)))
                        begin
                            guid_ok_next = 1'b0;
                        end
                    end

                    if (idx == 6'd1 && ftag_next != FMT_PCM && ftag_next != FMT_EXT)
                    begin
                        emit   = 1'b1;
                        status = ST_BAD_FORMAT;
                    end
                    else if (idx == 6'd1 && ftag_next == FMT_EXT && len_next < EXT_MIN_LEN)
                    begin
                        emit   = 1'b1;
                        status = ST_BAD_EXT;
                    end
                    else if (idx == GUID_LAST && ftag_next == FMT_EXT && !guid_ok_next)
                    begin
                        emit   = 1'b1;
                        status = ST_BAD_EXT;
                    end
                    else
                    begin
                        skip_next = skip_next - 32'd1;
                        if (idx != IDX_MAX)
                        begin
                            idx_next = idx + 6'd1;
                        end
                        lead = (idx >= 6'd1) && (idx < GUID_LAST);
                        if (skip_next == '0)
                        begin
                            fseen_next = 1'b1;
                            phase_next = PH_HDR;
                            idx_next   = '0;
                            tag_next   = '0;
                            len_next   = '0;
                            emit       = last;
                            status     = ST_EOF_CHUNK;
                        end
                        else
                        begin
                            emit = last;
                            if (ftag_next == FMT_EXT && lead)
                            begin
                                status = ST_EOF_EXT;
                            end
                            else
                            begin
                                status = ST_SHORT_FILE;
                            end
                        end
                    end
                end

                default:
                begin
                    if (skip_next != '0)
                    begin
                        skip_next = skip_next - 32'd1;
                    end
                    if (skip_next == '0)
                    begin
                        phase_next = PH_HDR;
                        idx_next   = '0;
                        tag_next   = '0;
                        len_next   = '0;
                        emit       = last;
                        status     = ST_EOF_CHUNK;
                    end
                    else
                    begin
                        emit   = last;
                        status = ST_SHORT_FILE;
                    end
                end
            endcase

            if (emit)
            begin
                done_next = 1'b1;
            end
        end
    end

    assign res_fire          = accept && emit;
    assign res.status        = status;
    assign res.no_format     = nofmt;
    assign res.sample_freq   = ok ? rate_next : '0;
    assign res.channel_count = ok ? chan_next : '0;
    assign res.sample_bits   = ok ? bits_next : '0;
    assign res.is_extensible = ok && (ftag_next == FMT_EXT);
    assign res.data_offset   = ok ? 32'(offset_next) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_RIFF;
            idx_reg     <= '0;
            tag_reg     <= '0;
            len_reg     <= '0;
            skip_reg    <= '0;
            offset_reg  <= '0;
            rate_reg    <= '0;
            chan_reg    <= '0;
            bits_reg    <= '0;
            ftag_reg    <= '0;
            fseen_reg   <= 1'b0;
            guid_ok_reg <= 1'b1;
            done_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            tag_reg     <= tag_next;
            len_reg     <= len_next;
            skip_reg    <= skip_next;
            offset_reg  <= offset_next;
            rate_reg    <= rate_next;
            chan_reg    <= chan_next;
            bits_reg    <= bits_next;
            ftag_reg    <= ftag_next;
            fseen_reg   <= fseen_next;
            guid_ok_reg <= guid_ok_next;
            done_reg    <= done_next;
        end
    end

endmodule

### rtl/core/wavhp_out_reg.sv
// result register between the parser and the result channel
module wavhp_out_reg
    import wavhp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  hdr_info_t load_info,
    output logic      busy,
    output logic      hdr_valid,
    input  logic      hdr_stall,
    output hdr_info_t hdr_info
);

    logic      valid_reg, valid_next;
    hdr_info_t info_reg;

    // full and held by the receiver
    assign busy = valid_reg && hdr_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!hdr_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            info_reg <= load_info;
        end
    end

    assign hdr_valid = valid_reg;
    assign hdr_info  = info_reg;

endmodule

### rtl/core/wav_header_parser_unit.sv
// top level of the wave file header parser
//
// file channel: one file byte per beat on file_valid / file_stall, with
// first_byte restarting the parse and last_byte marking the end of the file.
// hdr channel: at most one beat per file on hdr_valid / hdr_stall, giving
// status, format fields and the data offset, or an error code.
// result register: the result beat is registered and valid in the cycle after the
// byte that ends the parse (data chunk header, bad field or end of file) is taken.
// throughput: one byte per cycle while file_stall is low; the parse registers
// update on every taken byte.
// reset: parse state returns to the riff header phase and the result register
// empties; bytes without a leading first_byte parse as a new file.
// stall: a pending result is held stable while hdr_stall is high, and
// file_stall is raised only while that result register is full and stalled.
// bytes after a result are taken and dropped until the next first_byte.
module wav_header_parser_unit
    import wavhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       file_valid,
    output logic       file_stall,
    input  file_beat_t file_beat,
    output logic       hdr_valid,
    input  logic       hdr_stall,
    output hdr_info_t  hdr_info
);

    logic      accept;
    logic      busy;
    logic      res_fire;
    hdr_info_t res;

    assign file_stall = busy;
    assign accept     = file_valid && !busy;

    wavhp_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .beat     (file_beat),
        .res_fire (res_fire),
        .res      (res)
    );

    wavhp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_fire),
        .load_info (res),
        .busy      (busy),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .hdr_info  (hdr_info)
    );

endmodule
